[src/ec2d_pkg.sv]
package ec2d_pkg;

   // Word format: signed Q(WORD_WIDTH-16).16.
   localparam int WORD_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // Differences of two words.
   localparam int DIFF_WIDTH = WORD_WIDTH + 1;
   // Product of two differences.
   localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
   // Dot product numerator, signed.
   localparam int NUM_WIDTH  = PROD_WIDTH + 1;
   // Squared distance, unsigned.
   localparam int DEN_WIDTH  = PROD_WIDTH;
   // Numerator magnitude after the fractional shift.
   localparam int MAG_WIDTH  = NUM_WIDTH + FRAC_BITS;
   // Quotient magnitude bits (the ratio is bounded by the velocity range).
   localparam int QUO_WIDTH  = WORD_WIDTH + FRAC_BITS + 1;
   // Signed ratio and its split for the two narrower multipliers.
   localparam int K_WIDTH    = QUO_WIDTH + 1;
   localparam int KLO_WIDTH  = K_WIDTH / 2;
   localparam int KHI_WIDTH  = K_WIDTH - KLO_WIDTH;
   localparam int PHI_WIDTH  = KHI_WIDTH + DIFF_WIDTH;
   localparam int PLO_WIDTH  = KLO_WIDTH + 1 + DIFF_WIDTH;
   // Full ratio times distance, then after the fractional shift.
   localparam int FULL_WIDTH = K_WIDTH + DIFF_WIDTH;
   localparam int ADJ_WIDTH  = FULL_WIDTH - FRAC_BITS;
   localparam int SUM_WIDTH  = ADJ_WIDTH + 1;

   // Stream widths.
   localparam int REQ_BITS   = 8 * WORD_WIDTH;
   localparam int REQ_WIDTH  = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = 4 * WORD_WIDTH + 2;
   localparam int RSP_WIDTH  = ((RSP_BITS + 7) / 8) * 8;

   // Values that ride along with an item through the pipeline.
   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] v1x;
      logic signed [WORD_WIDTH-1:0] v1y;
      logic signed [WORD_WIDTH-1:0] v2x;
      logic signed [WORD_WIDTH-1:0] v2y;
      logic signed [DIFF_WIDTH-1:0] dx;
      logic signed [DIFF_WIDTH-1:0] dy;
   } carry_type;

   // Clamp a wide signed value to one word; bit WORD_WIDTH is the clamp flag.
   function automatic logic [WORD_WIDTH:0] sat_word(input logic signed [SUM_WIDTH-1:0] val);
      logic [SUM_WIDTH-WORD_WIDTH:0] top;
      logic [WORD_WIDTH:0]           res;
      top = val[SUM_WIDTH-1:WORD_WIDTH-1];
      if (&top || ~|top) begin
         res = {1'b0, val[WORD_WIDTH-1:0]};
      end else if (val[SUM_WIDTH-1]) begin
         res = {1'b1, 1'b1, {(WORD_WIDTH-1){1'b0}}};
      end else begin
         res = {1'b1, 1'b0, {(WORD_WIDTH-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

[src/elastic_collision_2d.sv]
// Path: a request word passes stages 1 to 3, the restoring divider (one quotient bit
// per stage), stages 5 to 7 and the response register before its response word.
// Throughput: one word per cycle; the whole pipeline holds while a response waits.
// Reset: synchronous, active high; clears every stage valid bit, data is not reset.
module elastic_collision_2d
   import ec2d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // first_pos_x, first_pos_y, first_vel_x, first_vel_y,
   // second_pos_x, second_pos_y, second_vel_x, second_vel_y
   input  logic [REQ_WIDTH-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y,
   // coincident, saturated, zero fill
   output logic [RSP_WIDTH-1:0] rsp_tdata
);

   logic advance;

   // Input fields.
   logic signed [WORD_WIDTH-1:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
   assign p1x = req_tdata[0*WORD_WIDTH +: WORD_WIDTH];
   assign p1y = req_tdata[1*WORD_WIDTH +: WORD_WIDTH];
   assign v1x = req_tdata[2*WORD_WIDTH +: WORD_WIDTH];
   assign v1y = req_tdata[3*WORD_WIDTH +: WORD_WIDTH];
   assign p2x = req_tdata[4*WORD_WIDTH +: WORD_WIDTH];
   assign p2y = req_tdata[5*WORD_WIDTH +: WORD_WIDTH];
   assign v2x = req_tdata[6*WORD_WIDTH +: WORD_WIDTH];
   assign v2y = req_tdata[7*WORD_WIDTH +: WORD_WIDTH];

   // Stage registers.
   logic                          s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic                          s5_vld_ff, s6_vld_ff, s7_vld_ff, out_vld_ff;
   carry_type                     s1_cy_ff, s2_cy_ff, s3_cy_ff, s5_cy_ff, s6_cy_ff, s7_cy_ff;
   carry_type                     s1_cy_in;
   logic signed [DIFF_WIDTH-1:0]  s1_dvx_ff, s1_dvy_ff;
   logic signed [PROD_WIDTH-1:0]  s2_dxv_ff, s2_dyv_ff, s2_dxx_ff, s2_dyy_ff;
   logic signed [NUM_WIDTH-1:0]   s3_num_ff;
   logic [DEN_WIDTH-1:0]          s3_den_ff;
   logic                          s3_co_ff, s5_co_ff, s6_co_ff, s7_co_ff;
   logic signed [K_WIDTH-1:0]     s5_k_ff;
   logic signed [PHI_WIDTH-1:0]   s6_phx_ff, s6_phy_ff;
   logic signed [PLO_WIDTH-1:0]   s6_plx_ff, s6_ply_ff;
   logic signed [ADJ_WIDTH-1:0]   s7_ax_ff, s7_ay_ff;
   logic [RSP_WIDTH-1:0]          out_data_ff;

   // Divider entries: entry 0 is loaded, entry QUO_WIDTH holds the quotient.
   logic                          dv_vld_ff [QUO_WIDTH+1];
   logic [DEN_WIDTH-1:0]          dv_rem_ff [QUO_WIDTH+1];
   logic [QUO_WIDTH-1:0]          dv_num_ff [QUO_WIDTH+1];
   logic [DEN_WIDTH-1:0]          dv_den_ff [QUO_WIDTH+1];
   logic                          dv_neg_ff [QUO_WIDTH+1];
   logic                          dv_co_ff  [QUO_WIDTH+1];
   carry_type                     dv_cy_ff  [QUO_WIDTH+1];
   logic [DEN_WIDTH-1:0]          dv_rem_in [QUO_WIDTH];
   logic [QUO_WIDTH-1:0]          dv_num_in [QUO_WIDTH];

   // The pipeline moves as a whole unless a response is waiting.
   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         s7_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i <= QUO_WIDTH; i++) begin
            dv_vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         s1_vld_ff    <= req_tvalid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         dv_vld_ff[0] <= s3_vld_ff;
         for (int i = 1; i <= QUO_WIDTH; i++) begin
            dv_vld_ff[i] <= dv_vld_ff[i-1];
         end
         s5_vld_ff  <= dv_vld_ff[QUO_WIDTH];
         s6_vld_ff  <= s5_vld_ff;
         s7_vld_ff  <= s6_vld_ff;
         out_vld_ff <= s7_vld_ff;
      end
   end

   // Stage 1: differences of positions and velocities.
   always_comb begin
      s1_cy_in.v1x = v1x;
      s1_cy_in.v1y = v1y;
      s1_cy_in.v2x = v2x;
      s1_cy_in.v2y = v2y;
      s1_cy_in.dx  = DIFF_WIDTH'(p2x) - DIFF_WIDTH'(p1x);
      s1_cy_in.dy  = DIFF_WIDTH'(p2y) - DIFF_WIDTH'(p1y);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cy_ff  <= s1_cy_in;
         s1_dvx_ff <= DIFF_WIDTH'(v1x) - DIFF_WIDTH'(v2x);
         s1_dvy_ff <= DIFF_WIDTH'(v1y) - DIFF_WIDTH'(v2y);
      end
   end

   // Stage 2: the four products of the dot products.
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_cy_ff  <= s1_cy_ff;
         s2_dxv_ff <= s1_dvx_ff * s1_cy_ff.dx;
         s2_dyv_ff <= s1_dvy_ff * s1_cy_ff.dy;
         s2_dxx_ff <= s1_cy_ff.dx * s1_cy_ff.dx;
         s2_dyy_ff <= s1_cy_ff.dy * s1_cy_ff.dy;
      end
   end

   // Stage 3: numerator, squared distance and the coincident flag.
   always_ff @(posedge clock) begin
      if (advance) begin
         s3_cy_ff  <= s2_cy_ff;
         s3_num_ff <= NUM_WIDTH'(s2_dxv_ff) + NUM_WIDTH'(s2_dyv_ff);
         s3_den_ff <= DEN_WIDTH'(unsigned'(s2_dxx_ff)) + DEN_WIDTH'(unsigned'(s2_dyy_ff));
         s3_co_ff  <= (s2_cy_ff.dx == '0) && (s2_cy_ff.dy == '0);
      end
   end

   // Numerator magnitude with the fractional shift, split for the divider.
   logic                 s3_neg;
   logic [NUM_WIDTH-1:0] s3_abs;
   logic [MAG_WIDTH-1:0] s3_mag;
   always_comb begin
      s3_neg = s3_num_ff[NUM_WIDTH-1];
      s3_abs = s3_neg ? NUM_WIDTH'(-s3_num_ff) : NUM_WIDTH'(s3_num_ff);
      s3_mag = {s3_abs, {FRAC_BITS{1'b0}}};
   end

   // Divider steps: one quotient bit per entry, the quotient shifts in behind
   // the numerator bits as they shift out.
   always_comb begin
      for (int i = 0; i < QUO_WIDTH; i++) begin
         logic [DEN_WIDTH:0] trial;
         logic               take;
         trial = {dv_rem_ff[i], dv_num_ff[i][QUO_WIDTH-1]};
         take  = trial >= {1'b0, dv_den_ff[i]};
         dv_rem_in[i] = take ? DEN_WIDTH'(trial - {1'b0, dv_den_ff[i]})
                             : DEN_WIDTH'(trial);
         dv_num_in[i] = {dv_num_ff[i][QUO_WIDTH-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_rem_ff[0] <= DEN_WIDTH'(s3_mag[MAG_WIDTH-1:QUO_WIDTH]);
         dv_num_ff[0] <= s3_mag[QUO_WIDTH-1:0];
         dv_den_ff[0] <= s3_den_ff;
         dv_neg_ff[0] <= s3_neg;
         dv_co_ff[0]  <= s3_co_ff;
         dv_cy_ff[0]  <= s3_cy_ff;
         for (int i = 1; i <= QUO_WIDTH; i++) begin
            dv_rem_ff[i] <= dv_rem_in[i-1];
            dv_num_ff[i] <= dv_num_in[i-1];
            dv_den_ff[i] <= dv_den_ff[i-1];
            dv_neg_ff[i] <= dv_neg_ff[i-1];
            dv_co_ff[i]  <= dv_co_ff[i-1];
            dv_cy_ff[i]  <= dv_cy_ff[i-1];
         end
      end
   end

   // Stage 5: signed ratio, truncated toward zero.
   logic [K_WIDTH-1:0] quo_ext;
   assign quo_ext = K_WIDTH'(dv_num_ff[QUO_WIDTH]);

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_cy_ff <= dv_cy_ff[QUO_WIDTH];
         s5_co_ff <= dv_co_ff[QUO_WIDTH];
         s5_k_ff  <= dv_neg_ff[QUO_WIDTH] ? signed'(-quo_ext) : signed'(quo_ext);
      end
   end

   // Stage 6: ratio times distance as two partial products per axis.
   logic signed [KHI_WIDTH-1:0] k_hi;
   logic signed [KLO_WIDTH:0]   k_lo;
   assign k_hi = s5_k_ff[K_WIDTH-1:KLO_WIDTH];
   assign k_lo = signed'({1'b0, s5_k_ff[KLO_WIDTH-1:0]});

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_cy_ff  <= s5_cy_ff;
         s6_co_ff  <= s5_co_ff;
         s6_phx_ff <= k_hi * s5_cy_ff.dx;
         s6_phy_ff <= k_hi * s5_cy_ff.dy;
         s6_plx_ff <= k_lo * s5_cy_ff.dx;
         s6_ply_ff <= k_lo * s5_cy_ff.dy;
      end
   end

   // Stage 7: join the partial products and floor the fractional shift.
   logic signed [FULL_WIDTH-1:0] full_x, full_y;
   always_comb begin
      full_x = (FULL_WIDTH'(s6_phx_ff) <<< KLO_WIDTH) + FULL_WIDTH'(s6_plx_ff);
      full_y = (FULL_WIDTH'(s6_phy_ff) <<< KLO_WIDTH) + FULL_WIDTH'(s6_ply_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_cy_ff <= s6_cy_ff;
         s7_co_ff <= s6_co_ff;
         s7_ax_ff <= full_x[FULL_WIDTH-1:FRAC_BITS];
         s7_ay_ff <= full_y[FULL_WIDTH-1:FRAC_BITS];
      end
   end

   // Stage 8: new velocities, clamped, or the old velocities for coincident centres, into the response register.
   logic [WORD_WIDTH:0]  sat1x, sat1y, sat2x, sat2y;
   logic [RSP_WIDTH-1:0] out_data_in;
   always_comb begin
      sat1x = sat_word(SUM_WIDTH'(s7_cy_ff.v1x) - SUM_WIDTH'(s7_ax_ff));
      sat1y = sat_word(SUM_WIDTH'(s7_cy_ff.v1y) - SUM_WIDTH'(s7_ay_ff));
      sat2x = sat_word(SUM_WIDTH'(s7_cy_ff.v2x) + SUM_WIDTH'(s7_ax_ff));
      sat2y = sat_word(SUM_WIDTH'(s7_cy_ff.v2y) + SUM_WIDTH'(s7_ay_ff));
      out_data_in = '0;
      if (s7_co_ff) begin
         out_data_in[RSP_BITS-1:0] = {1'b0, 1'b1, s7_cy_ff.v2y, s7_cy_ff.v2x,
                                      s7_cy_ff.v1y, s7_cy_ff.v1x};
      end else begin
         out_data_in[RSP_BITS-1:0] = {sat1x[WORD_WIDTH] | sat1y[WORD_WIDTH] |
                                      sat2x[WORD_WIDTH] | sat2y[WORD_WIDTH], 1'b0,
                                      sat2y[WORD_WIDTH-1:0], sat2x[WORD_WIDTH-1:0],
                                      sat1y[WORD_WIDTH-1:0], sat1x[WORD_WIDTH-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

[src/ec2d_checker.sv]
module ec2d_checker
   import ec2d_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [REQ_WIDTH-1:0] req_tdata,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RSP_WIDTH-1:0] rsp_tdata
);

   // A waiting response word stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word dropped while stalled");

   // A waiting response word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // A stalled response holds the whole pipeline, so no request word enters.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while the pipeline is held");

   // Coincident centres never report a clamp.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[4*WORD_WIDTH] && rsp_tdata[4*WORD_WIDTH+1]))
      else $error("coincident and saturated both set");

   // Nothing comes out in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response word right after reset");

endmodule

bind elastic_collision_2d ec2d_checker u_ec2d_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
